// File: rtl/lpf_pkg.sv
package lpf_pkg;

  localparam int TableLen = 24;
  localparam int DefCordicStages = 16;
  localparam int PhaseW = 34;
  localparam int CsW = 34;
  localparam logic signed [CsW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [CsW-1:0] OneQ30 = 34'sd1073741824;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam logic [0:0] CfgIdxMinConf = 1'b0;
  localparam logic [0:0] CfgIdxArtEn = 1'b1;

  typedef struct packed {
    logic [15:0] range_cm;
    logic signed [15:0] azimuth_code;
    logic signed [15:0] elevation_code;
    logic [7:0] reflectivity;
  } lpf_point_t;

  typedef struct packed {
    logic signed [CsW-1:0] x;
    logic signed [CsW-1:0] y;
    logic signed [PhaseW-1:0] z;
    logic flip;
  } lpf_cordic_t;

  function automatic logic signed [PhaseW-1:0] atan_entry(input int i);
    logic signed [PhaseW-1:0] v;
    begin
      unique case (i)
        0: v = 34'sd536870912;
        1: v = 34'sd316933406;
        2: v = 34'sd167458907;
        3: v = 34'sd85004756;
        4: v = 34'sd42667331;
        5: v = 34'sd21354465;
        6: v = 34'sd10679838;
        7: v = 34'sd5340245;
        8: v = 34'sd2670163;
        9: v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41721;
        15: v = 34'sd20861;
        16: v = 34'sd10430;
        17: v = 34'sd5215;
        18: v = 34'sd2608;
        19: v = 34'sd1304;
        20: v = 34'sd652;
        21: v = 34'sd326;
        22: v = 34'sd163;
        23: v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic lpf_cordic_t cordic_init(input logic signed [15:0] code);
    lpf_cordic_t c;
    logic signed [16:0] k;
    begin
      k = 17'(code);
      c.flip = 1'b0;
      if (code > 16'sd16383) begin
        k = k - 17'sd32768;
        c.flip = 1'b1;
      end else if (code < -16'sd16384) begin
        k = k + 17'sd32768;
        c.flip = 1'b1;
      end
      c.x = GainQ30;
      c.y = '0;
      c.z = PhaseW'(k) <<< 16;
      return c;
    end
  endfunction

  function automatic lpf_cordic_t cordic_step(input lpf_cordic_t c, input int i);
    lpf_cordic_t n;
    begin
      n = c;
      if (!c.z[PhaseW-1]) begin
        n.x = c.x - (c.y >>> i);
        n.y = c.y + (c.x >>> i);
        n.z = c.z - atan_entry(i);
      end else begin
        n.x = c.x + (c.y >>> i);
        n.y = c.y - (c.x >>> i);
        n.z = c.z + atan_entry(i);
      end
      return n;
    end
  endfunction

  function automatic logic signed [CsW-1:0] cs_final(input logic signed [CsW-1:0] v,
                                                    input logic flip);
    logic signed [CsW-1:0] t;
    begin
      t = flip ? -v : v;
      if (t > OneQ30) t = OneQ30;
      else if (t < -OneQ30) t = -OneQ30;
      return t;
    end
  endfunction

endpackage

// File: rtl/lpf_front.sv
module lpf_front import lpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  lpf_point_t  in_point,
  input  logic [7:0]  in_confidence,
  input  logic        in_artifact,
  output logic        q_valid,
  input  logic        q_ready,
  output lpf_point_t  q_point
);

  logic [7:0] min_conf_r;
  logic       art_en_r;
  lpf_point_t mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0] cnt_r;
  logic keep, push, pop;

  assign in_ready = (cnt_r != (QPtrW+1)'(QDepth)) || pop;
  assign keep = (in_point.range_cm != 16'd0) && (in_confidence >= min_conf_r) &&
                !(art_en_r && in_artifact);
  assign push = in_valid && in_ready && keep;
  assign q_valid = cnt_r != '0;
  assign pop = q_valid && q_ready;
  assign q_point = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_conf_r <= '0;
      art_en_r <= 1'b0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgIdxMinConf) min_conf_r <= cfg_data;
        if (cfg_index == CfgIdxArtEn) art_en_r <= cfg_data[0];
      end
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_point;
  end

endmodule

// File: rtl/lpf_back.sv
module lpf_back import lpf_pkg::*; #(
  parameter int CORDIC_STAGES = DefCordicStages
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  lpf_point_t  q_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [135:0] out_data
);

  localparam int NS = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
  localparam int NP = NS + 4;

  logic        vld_r [NP];
  lpf_point_t  pt_r [NP];
  lpf_cordic_t ca_r [NS];
  lpf_cordic_t ce_r [NS];
  logic signed [CsW-1:0] cosa_r, sina_r, cose_r, sine_r;
  logic signed [CsW-1:0] cosa2_r, sina2_r;
  logic signed [CsW-1:0] cosa3_r, sina3_r;
  logic signed [49:0] pr_r, pz_r;
  logic signed [25:0] r_r, z_r;
  logic signed [59:0] px_r, py_r;
  logic signed [24:0] x_o, y_o, z_o;
  logic signed [24:0] z2_r;
  logic signed [24:0] lim2;
  logic advance;
  logic signed [25:0] lim1;
  logic signed [24:0] lim3;

  assign advance = !vld_r[NP-1] || out_ready;
  assign q_ready = advance;
  assign out_valid = vld_r[NP-1];

  function automatic logic signed [24:0] sat(input logic signed [59:0] v,
                                             input logic signed [24:0] lim);
    logic signed [59:0] l;
    begin
      l = 60'(lim);
      if (v > l) return lim;
      if (v < -l) return -lim;
      return 25'(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) vld_r[i] <= 1'b0;
    end else if (advance) begin
      vld_r[0] <= q_valid;
      for (int i = 1; i < NP; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pt_r[0] <= q_point;
      for (int i = 1; i < NP; i++) pt_r[i] <= pt_r[i-1];
      ca_r[0] <= cordic_step(cordic_init(q_point.azimuth_code), 0);
      ce_r[0] <= cordic_step(cordic_init(q_point.elevation_code), 0);
      for (int i = 1; i < NS; i++) begin
        ca_r[i] <= cordic_step(ca_r[i-1], i);
        ce_r[i] <= cordic_step(ce_r[i-1], i);
      end
      cosa_r <= cs_final(ca_r[NS-1].x, ca_r[NS-1].flip);
      sina_r <= cs_final(ca_r[NS-1].y, ca_r[NS-1].flip);
      cose_r <= cs_final(ce_r[NS-1].x, ce_r[NS-1].flip);
      sine_r <= cs_final(ce_r[NS-1].y, ce_r[NS-1].flip);
      pr_r <= $signed({1'b0, pt_r[NS].range_cm}) * cose_r;
      pz_r <= $signed({1'b0, pt_r[NS].range_cm}) * sine_r;
      cosa2_r <= cosa_r;
      sina2_r <= sina_r;
      cosa3_r <= cosa2_r;
      sina3_r <= sina2_r;
      r_r <= 26'((pr_r + 50'sd2097152) >>> 22);
      z_r <= 26'((pz_r + 50'sd2097152) >>> 22);
      px_r <= r_r * cosa3_r;
      py_r <= r_r * sina3_r;
      z2_r <= sat(60'(z_r), lim2);
    end
  end

  assign lim1 = 26'({pt_r[NS+2].range_cm, 8'd0});
  assign lim2 = 25'(lim1);
  assign lim3 = 25'({pt_r[NP-1].range_cm, 8'd0});
  assign x_o = sat((px_r + 60'sd536870912) >>> 30, lim3);
  assign y_o = sat((py_r + 60'sd536870912) >>> 30, lim3);
  assign z_o = z2_r;

  assign out_data = {5'd0, pt_r[NP-1].reflectivity, pt_r[NP-1].elevation_code,
                     pt_r[NP-1].azimuth_code, pt_r[NP-1].range_cm, z_o, y_o, x_o};

endmodule

// File: rtl/lidar_point_filter_polar_to_xyz.sv
// Throughput: one beat per cycle through the fully pipelined CORDIC and multipliers, unless out_tready stalls it.
// Rejected points are dropped in the front end and produce no result beat.
// Reset is synchronous and active low; it clears the queue, pipeline valids and config registers.
module lidar_point_filter_polar_to_xyz import lpf_pkg::*; #(
  parameter int CORDIC_STAGES = DefCordicStages
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // range_cm, azimuth_code, elevation_code, confidence, artifact_flag, reflectivity
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // x_pos, y_pos, z_pos, range_out, azimuth_out, elevation_out, intensity
  output logic [135:0] out_tdata
);

  lpf_point_t in_point, q_point;
  logic q_valid, q_ready;

  assign in_point.range_cm = in_tdata[15:0];
  assign in_point.azimuth_code = in_tdata[31:16];
  assign in_point.elevation_code = in_tdata[47:32];
  assign in_point.reflectivity = in_tdata[64:57];

  lpf_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_point(in_point), .in_confidence(in_tdata[55:48]),
    .in_artifact(in_tdata[56]), .q_valid(q_valid), .q_ready(q_ready),
    .q_point(q_point)
  );

  lpf_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_point(q_point), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb import lpf_pkg::*;;

  localparam int Stages = 16;
  localparam int Latency = Stages + 4;
  localparam int WatchdogLimit = 5000;

  typedef struct {
    logic [15:0] range_cm;
    logic signed [15:0] az;
    logic signed [15:0] el;
    logic [7:0] conf;
    logic art;
    logic [7:0] refl;
  } point_t;

  typedef struct {
    logic [24:0] x;
    logic [24:0] y;
    logic [24:0] z;
    logic [15:0] range_cm;
    logic [15:0] az;
    logic [15:0] el;
    logic [7:0] refl;
  } xyz_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;

  logic [7:0] min_conf_q = '0;
  logic art_en_q = 1'b0;
  xyz_t xyz_queue[$];
  int errors = 0;
  int points_sent = 0;
  int points_kept = 0;
  int idle_cycles = 0;
  int send_gap_max = 5;
  int recv_stall_max = 5;
  int stall_left = 0;
  bit timed_out = 1'b0;

  lidar_point_filter_polar_to_xyz #(.CORDIC_STAGES(Stages)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint atan_val(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41721, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic longint limit_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void rotate_angle(int code, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    flip = 1'b0;
    if (code > 16383) begin
      code -= 32768;
      flip = 1'b1;
    end else if (code < -16384) begin
      code += 32768;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = longint'(code) * 65536;
    for (int i = 0; i < Stages && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_val(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_val(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = limit_to(x, 1 << 30);
    s = limit_to(y, 1 << 30);
  endfunction

  function automatic bit project_point(point_t p, output xyz_t r);
    longint d, ca, sa, ce, se, rr, lim;
    if (p.range_cm == 0 || p.conf < min_conf_q || (art_en_q && p.art)) return 1'b0;
    d = p.range_cm;
    rotate_angle(p.az, ca, sa);
    rotate_angle(p.el, ce, se);
    lim = d * 256;
    rr = (d * ce + (64'sd1 <<< 21)) >>> 22;
    r.z = 25'(limit_to((d * se + (64'sd1 <<< 21)) >>> 22, lim));
    r.x = 25'(limit_to((rr * ca + (64'sd1 <<< 29)) >>> 30, lim));
    r.y = 25'(limit_to((rr * sa + (64'sd1 <<< 29)) >>> 30, lim));
    r.range_cm = p.range_cm;
    r.az = p.az;
    r.el = p.el;
    r.refl = p.refl;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic send_point(point_t p);
    xyz_t r;
    if (send_gap_max > 0 && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, send_gap_max)) @(negedge clk);
    end
    in_tdata <= {7'b0, p.refl, p.art, p.conf, p.el, p.az, p.range_cm};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (project_point(p, r)) begin
      xyz_queue.push_back(r);
      points_kept++;
    end
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (xyz_queue.size() > 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    drain_and_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgIdxMinConf) min_conf_q = val;
    else art_en_q = val[0];
  endtask

  function automatic point_t random_point();
    point_t p;
    p.range_cm = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    p.az = 16'($urandom);
    p.el = 16'($urandom);
    p.conf = 8'($urandom);
    p.art = 1'($urandom);
    p.refl = 8'($urandom);
    return p;
  endfunction

  function automatic point_t mk(logic [15:0] d, logic signed [15:0] a, logic signed [15:0] e,
                                logic [7:0] c, logic f, logic [7:0] rf);
    point_t p;
    p.range_cm = d; p.az = a; p.el = e; p.conf = c; p.art = f; p.refl = rf;
    return p;
  endfunction

  task automatic test_directed_extremes();
    logic signed [15:0] angles[10] = '{16'sd0, 16'sd16383, 16'sd16384, -16'sd16384,
                                      -16'sd16385, 16'sd32767, -16'sd32768, 16'sd8192,
                                      -16'sd8192, 16'sd1};
    send_point(mk(16'd0, 16'sd0, 16'sd0, 8'd255, 1'b0, 8'd1));
    send_point(mk(16'hFFFF, 16'sd0, 16'sd0, 8'd0, 1'b1, 8'hFF));
    send_point(mk(16'd1, 16'sd0, 16'sd0, 8'd0, 1'b0, 8'd0));
    foreach (angles[i]) send_point(mk(16'hFFFF, angles[i], angles[9 - i], 8'hAA, 1'b0, 8'h55));
    send_point(mk(16'd1, 16'sd16384, -16'sd32768, 8'd1, 1'b1, 8'd2));
  endtask

  task automatic test_confidence_threshold();
    write_reg(CfgIdxMinConf, 8'd255);
    send_point(mk(16'd500, 16'sd100, 16'sd50, 8'd254, 1'b0, 8'd3));
    send_point(mk(16'd500, 16'sd100, 16'sd50, 8'd255, 1'b0, 8'd4));
    write_reg(CfgIdxMinConf, 8'd128);
    send_point(mk(16'd500, 16'sd100, 16'sd50, 8'd127, 1'b0, 8'd5));
    send_point(mk(16'd500, 16'sd100, 16'sd50, 8'd128, 1'b0, 8'd6));
  endtask

  task automatic test_artifact_filter();
    write_reg(CfgIdxArtEn, 8'd1);
    write_reg(CfgIdxMinConf, 8'd0);
    send_point(mk(16'd700, -16'sd300, 16'sd20, 8'd0, 1'b1, 8'd7));
    send_point(mk(16'd700, -16'sd300, 16'sd20, 8'd0, 1'b0, 8'd8));
  endtask

  task automatic test_random_phases();
    logic [7:0] conf_set[4] = '{8'd0, 8'd40, 8'd200, 8'd255};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgIdxMinConf, conf_set[ph]);
      write_reg(CfgIdxArtEn, 8'(ph % 2));
      repeat (250) send_point(random_point());
    end
    send_gap_max = 0;
    recv_stall_max = 0;
    write_reg(CfgIdxMinConf, 8'd0);
    write_reg(CfgIdxArtEn, 8'd0);
    repeat (300) send_point(random_point());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_confidence_threshold();
    test_artifact_filter();
    test_random_phases();
    drain_and_idle();
    $display("Sent %0d points, %0d passed the filter and were checked as XYZ beats.",
             points_sent, points_kept);
    $display("Runs covered confidence thresholds 0 to 255, artifact filter on and off.");
    if (errors == 0 && !timed_out) begin
      $display("lidar_point_filter_polar_to_xyz test passed");
    end else begin
      $display("lidar_point_filter_polar_to_xyz test failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_stall_max > 0 && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, recv_stall_max - 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    xyz_t w;
    if (out_tvalid && out_tready) begin
      if (xyz_queue.size() == 0) begin
        report_mismatch("unexpected beat", longint'(out_tdata[63:0]), 0);
      end else begin
        w = xyz_queue.pop_front();
        if (out_tdata[24:0] !== w.x) report_mismatch("x_pos", out_tdata[24:0], w.x);
        if (out_tdata[49:25] !== w.y) report_mismatch("y_pos", out_tdata[49:25], w.y);
        if (out_tdata[74:50] !== w.z) report_mismatch("z_pos", out_tdata[74:50], w.z);
        if (out_tdata[90:75] !== w.range_cm)
          report_mismatch("range_out", out_tdata[90:75], w.range_cm);
        if (out_tdata[106:91] !== w.az) report_mismatch("azimuth_out", out_tdata[106:91], w.az);
        if (out_tdata[122:107] !== w.el)
          report_mismatch("elevation_out", out_tdata[122:107], w.el);
        if (out_tdata[130:123] !== w.refl)
          report_mismatch("intensity", out_tdata[130:123], w.refl);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        timed_out = 1'b1;
        $display("lidar_point_filter_polar_to_xyz test failed");
        $finish;
      end
    end
  end

endmodule
